// ===== rtl/mbg_pkg.sv =====
// ----------------------------------------------------------------------------
// Maze backtracker generator package
// Shared widths, reset values, result codes and the neighbor pick function.
// ----------------------------------------------------------------------------
package mbg_pkg;

  localparam int unsigned MAX_SIDE_DEF  = 64;
  localparam int unsigned GRID_W        = 7;
  localparam int unsigned RND_W         = 16;
  localparam int unsigned CELL_OUT_W    = 12;
  localparam logic [GRID_W-1:0] GRID_SIDE_RST = 7'd40;

  typedef enum logic [1:0] {
    EV_CARVED    = 2'd0,
    EV_BACKTRACK = 2'd1,
    EV_FINISHED  = 2'd2,
    EV_RESTARTED = 2'd3
  } ev_e;

  // Returns rnd modulo cnt for a neighbor count from one to four. The modulo
  // by three folds base-4 digits, since four is one modulo three.
  function automatic logic [1:0] pick_mod(input logic [RND_W-1:0] rnd,
                                          input logic [2:0] cnt);
    logic [4:0] s;
    logic [2:0] f;
    logic [1:0] r3;
    logic [1:0] res;
    s = '0;
    for (int i = 0; i < RND_W / 2; i++) begin
      s = s + 5'(rnd[2*i +: 2]);
    end
    f = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
    if (f >= 3'd6) begin
      r3 = 2'(f - 3'd6);
    end else if (f >= 3'd3) begin
      r3 = 2'(f - 3'd3);
    end else begin
      r3 = f[1:0];
    end
    case (cnt)
      3'd1:    res = 2'd0;
      3'd2:    res = {1'b0, rnd[0]};
      3'd3:    res = r3;
      default: res = rnd[1:0];
    endcase
    return res;
  endfunction

endpackage

// ===== rtl/mbg_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mbg_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/mbg_rem.sv =====
// ----------------------------------------------------------------------------
// Iterative remainder unit
// Restoring division, one dividend bit per cycle; only the remainder is kept.
// ----------------------------------------------------------------------------
module mbg_rem #(
  parameter int unsigned N_W = 12,
  parameter int unsigned D_W = 7
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [N_W-1:0] dividend_i,
  input  logic [D_W-1:0] divisor_i,
  output logic           done_o,
  output logic [D_W-1:0] rem_o
);

  localparam int unsigned CNT_W = $clog2(N_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [N_W-1:0]   dvd_q, dvd_d;
  logic [D_W-1:0]   div_q, div_d;
  logic [D_W-1:0]   rem_q, rem_d;
  logic [D_W:0]     trial;
  logic [D_W:0]     nxt;

  always_comb begin
    trial  = {rem_q, dvd_q[N_W-1]};
    nxt    = (trial >= {1'b0, div_q}) ? trial - {1'b0, div_q} : trial;
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(N_W);
      dvd_d  = dividend_i;
      div_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = nxt[D_W-1:0];
      dvd_d = dvd_q << 1;
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/maze_backtracker_generator.sv =====
// ----------------------------------------------------------------------------
// Maze backtracker generator
// Recursive backtracker over a square grid with visited map and cell stack in
// block RAM; one step item carves, backtracks, finishes or restarts.
// ----------------------------------------------------------------------------
// A step item passes through accept, four visited-map reads through the
// single read port plus a wait for the last read data, the pick, and the
// hand-off to the output register, which waits while an earlier result is
// still stalled. A backtrack that leaves at least two entries on the stack adds
// a stack read. When the column of the stack top is not known (after a
// backtrack that reads the stack, or a write of grid_side) a run of the
// remainder unit is added. A restart item, and reset, run a clearing pass
// over all MAX_SIDE*MAX_SIDE cells of the visited map (4096 at the default
// size) during which no item is accepted; configuration writes are taken at
// any time.
module maze_backtracker_generator
  import mbg_pkg::*;
#(
  parameter int unsigned MAX_SIDE = MAX_SIDE_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [GRID_W-1:0]     cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  mode_i,
  input  logic [RND_W-1:0]      random_value_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [1:0]            event_res_o,
  output logic [CELL_OUT_W-1:0] from_cell_o,
  output logic [CELL_OUT_W-1:0] to_cell_o
);

  localparam int unsigned CELL_COUNT = MAX_SIDE * MAX_SIDE;
  localparam int unsigned CW = $clog2(CELL_COUNT);
  localparam int unsigned TW = CW + 1;
  localparam int unsigned SW = $clog2(MAX_SIDE + 1);
  localparam int unsigned SX = SW + 1;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_DIV   = 7'b0000010,
    ST_SCAN  = 7'b0000100,
    ST_PICK  = 7'b0001000,
    ST_POP   = 7'b0010000,
    ST_DONE  = 7'b0100000,
    ST_CLEAR = 7'b1000000
  } state_e;

  state_e            state_q, state_d;
  logic [TW-1:0]     depth_q, depth_d;
  logic [CW-1:0]     top_q, top_d;
  logic [SW-1:0]     col_q, col_d;
  logic              colv_q, colv_d;
  logic [SW-1:0]     side_q, side_d;
  logic [TW-1:0]     total_q, total_d;
  logic [TW-1:0]     inner_q, inner_d;
  logic [RND_W-1:0]  rnd_q, rnd_d;
  logic [2:0]        sc_q, sc_d;
  logic [3:0]        free_q, free_d;
  logic [CW-1:0]     clr_q, clr_d;
  logic              restart_q, restart_d;
  ev_e               res_ev_q, res_ev_d;
  logic [CW-1:0]     res_from_q, res_from_d;
  logic [CW-1:0]     res_to_q, res_to_d;
  logic              out_valid_q, out_valid_d;
  ev_e               out_ev_q, out_ev_d;
  logic [CW-1:0]     out_from_q, out_from_d;
  logic [CW-1:0]     out_to_q, out_to_d;
  logic [GRID_W-1:0] grid_q, grid_d;

  logic [SW-1:0]     side_use;
  logic [TW-1:0]     cand [4];
  logic [3:0]        geo_ok;
  logic [TW-1:0]     top_x;
  logic [TW-1:0]     side_x;
  logic [1:0]        prev;
  logic [2:0]        cnt;
  logic [1:0]        k;
  logic [1:0]        sel;
  logic [2:0]        seen;
  logic [CW-1:0]     pick_cell;
  logic              accept;

  logic              vis_we;
  logic [CW-1:0]     vis_waddr;
  logic [0:0]        vis_wdata;
  logic [CW-1:0]     vis_raddr;
  logic [0:0]        vis_rdata;
  logic              stk_we;
  logic [CW-1:0]     stk_raddr;
  logic [CW-1:0]     stk_rdata;
  logic              div_start;
  logic              div_done;
  logic [SW-1:0]     div_rem;

  mbg_ram #(.WIDTH(1), .DEPTH(CELL_COUNT)) u_visited (
    .clk_i   (clk_i),
    .we_i    (vis_we),
    .waddr_i (vis_waddr),
    .wdata_i (vis_wdata),
    .raddr_i (vis_raddr),
    .rdata_o (vis_rdata)
  );

  mbg_ram #(.WIDTH(CW), .DEPTH(CELL_COUNT)) u_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (depth_q[CW-1:0]),
    .wdata_i (pick_cell),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  mbg_rem #(.N_W(CW), .D_W(SW)) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (top_q),
    .divisor_i  (side_use),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  always_comb begin
    if (grid_q == '0) begin
      side_use = SW'(1);
    end else if (32'(grid_q) > MAX_SIDE) begin
      side_use = SW'(MAX_SIDE);
    end else begin
      side_use = SW'(grid_q);
    end
  end

  always_comb begin
    top_x     = TW'(top_q);
    side_x    = TW'(side_q);
    cand[0]   = top_x - TW'(1);
    cand[1]   = top_x + TW'(1);
    cand[2]   = top_x - side_x;
    cand[3]   = top_x + side_x;
    geo_ok[0] = (col_q != '0) && (cand[0] < total_q);
    geo_ok[1] = ((SX'(col_q) + SX'(1)) < SX'(side_q)) && (cand[1] < total_q);
    geo_ok[2] = (top_x >= side_x) && (cand[2] < total_q);
    geo_ok[3] = (top_x < inner_q) && (cand[3] < total_q);
    cnt = 3'(free_q[0]) + 3'(free_q[1]) + 3'(free_q[2]) + 3'(free_q[3]);
    k   = pick_mod(rnd_q, cnt);
    sel  = '0;
    seen = '0;
    for (int i = 0; i < 4; i++) begin
      if (free_q[i] && (seen == {1'b0, k})) begin
        sel = 2'(i);
      end
      seen = seen + 3'(free_q[i]);
    end
    pick_cell = cand[sel][CW-1:0];
    prev      = 2'(sc_q - 3'd1);
  end

  assign accept    = in_valid_i && (state_q == ST_IDLE);
  assign div_start = accept && !mode_i && (depth_q != '0) && !colv_q;
  assign stk_raddr = CW'(depth_q - TW'(2));
  assign vis_raddr = cand[sc_q[1:0]][CW-1:0];

  always_comb begin
    state_d     = state_q;
    depth_d     = depth_q;
    top_d       = top_q;
    col_d       = col_q;
    colv_d      = colv_q;
    side_d      = side_q;
    total_d     = total_q;
    inner_d     = inner_q;
    rnd_d       = rnd_q;
    sc_d        = sc_q;
    free_d      = free_q;
    clr_d       = clr_q;
    restart_d   = restart_q;
    res_ev_d    = res_ev_q;
    res_from_d  = res_from_q;
    res_to_d    = res_to_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_ev_d    = out_ev_q;
    out_from_d  = out_from_q;
    out_to_d    = out_to_q;
    grid_d      = grid_q;
    vis_we      = 1'b0;
    vis_waddr   = pick_cell;
    vis_wdata   = 1'b1;
    stk_we      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          rnd_d = random_value_i;
          if (mode_i) begin
            clr_d     = '0;
            restart_d = 1'b1;
            state_d   = ST_CLEAR;
          end else if (depth_q == '0) begin
            res_ev_d   = EV_FINISHED;
            res_from_d = '0;
            res_to_d   = '0;
            state_d    = ST_DONE;
          end else begin
            side_d  = side_use;
            total_d = TW'(TW'(side_use) * TW'(side_use));
            inner_d = TW'(TW'(side_use) * TW'(side_use - SW'(1)));
            sc_d    = '0;
            state_d = colv_q ? ST_SCAN : ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          col_d   = div_rem;
          colv_d  = 1'b1;
          sc_d    = '0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sc_q != '0) begin
          free_d[prev] = geo_ok[prev] && !vis_rdata[0];
        end
        sc_d = sc_q + 3'd1;
        if (sc_q == 3'd4) begin
          state_d = ST_PICK;
        end
      end
      ST_PICK: begin
        if (cnt == '0) begin
          depth_d    = depth_q - TW'(1);
          res_ev_d   = EV_BACKTRACK;
          res_from_d = top_q;
          res_to_d   = '0;
          state_d    = ST_DONE;
          if (depth_q == TW'(2)) begin
            top_d  = '0;
            col_d  = '0;
            colv_d = 1'b1;
          end else if (depth_q != TW'(1)) begin
            state_d = ST_POP;
          end
        end else if (depth_q >= TW'(CELL_COUNT)) begin
          res_ev_d   = EV_FINISHED;
          res_from_d = '0;
          res_to_d   = '0;
          state_d    = ST_DONE;
        end else begin
          vis_we     = 1'b1;
          stk_we     = 1'b1;
          depth_d    = depth_q + TW'(1);
          top_d      = pick_cell;
          res_ev_d   = EV_CARVED;
          res_from_d = top_q;
          res_to_d   = pick_cell;
          state_d    = ST_DONE;
          if (sel == 2'd0) begin
            col_d = col_q - SW'(1);
          end else if (sel == 2'd1) begin
            col_d = col_q + SW'(1);
          end
        end
      end
      ST_POP: begin
        top_d    = stk_rdata;
        colv_d   = 1'b0;
        res_to_d = stk_rdata;
        state_d  = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_ev_d    = res_ev_q;
          out_from_d  = res_from_q;
          out_to_d    = res_to_q;
          state_d     = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        vis_we    = 1'b1;
        vis_waddr = clr_q;
        vis_wdata = (clr_q == '0);
        clr_d     = clr_q + CW'(1);
        if (clr_q == CW'(CELL_COUNT - 1)) begin
          depth_d   = TW'(1);
          top_d     = '0;
          col_d     = '0;
          colv_d    = 1'b1;
          restart_d = 1'b0;
          if (restart_q) begin
            res_ev_d   = EV_RESTARTED;
            res_from_d = '0;
            res_to_d   = '0;
            state_d    = ST_DONE;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (cfg_we_i) begin
      grid_d = cfg_wdata_i;
      colv_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      depth_q     <= TW'(1);
      top_q       <= '0;
      col_q       <= '0;
      colv_q      <= 1'b1;
      sc_q        <= '0;
      clr_q       <= '0;
      restart_q   <= 1'b0;
      out_valid_q <= 1'b0;
      grid_q      <= GRID_SIDE_RST;
    end else begin
      state_q     <= state_d;
      depth_q     <= depth_d;
      top_q       <= top_d;
      col_q       <= col_d;
      colv_q      <= colv_d;
      sc_q        <= sc_d;
      clr_q       <= clr_d;
      restart_q   <= restart_d;
      out_valid_q <= out_valid_d;
      grid_q      <= grid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    side_q     <= side_d;
    total_q    <= total_d;
    inner_q    <= inner_d;
    rnd_q      <= rnd_d;
    free_q     <= free_d;
    res_ev_q   <= res_ev_d;
    res_from_q <= res_from_d;
    res_to_q   <= res_to_d;
    out_ev_q   <= out_ev_d;
    out_from_q <= out_from_d;
    out_to_q   <= out_to_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign event_res_o = out_ev_q;
  assign from_cell_o = CELL_OUT_W'(out_from_q);
  assign to_cell_o   = CELL_OUT_W'(out_to_q);

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= TW'(CELL_COUNT))
    else $error("stack depth beyond cell count");

  a_rem_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV) && (div_rem < side_q))
    else $error("remainder result outside column computation");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("output item loaded outside result hand-off");

  a_scan_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (col_q < side_q))
    else $error("column of stack top not below grid side");

endmodule
